// ===== design/particle_circle_bounce_step_defines.svh =====
`ifndef PARTICLE_CIRCLE_BOUNCE_STEP_DEFINES_SVH
`define PARTICLE_CIRCLE_BOUNCE_STEP_DEFINES_SVH

// same-cycle implication checked on every clock edge outside reset
`define PCB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked on every clock edge outside reset
`define PCB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pcb_pkg.sv =====
package pcb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FIELD_W   = 20;
	localparam int RAD_W     = 16;
	localparam int ATT_W     = 18;
	localparam int DT_W      = 16;
	localparam logic [DT_W-1:0] DT_RESET = 16'd328;

	localparam int IN_W  = 160;
	localparam int OUT_W = 80;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	localparam int SQ_STAGES = 16;
	localparam int DIV_NW    = 56;
	localparam int DIV_DW    = 32;
	localparam int DIV_QW    = 22;

	localparam logic signed [FIELD_W-1:0] FIELD_MAX = 20'sh7FFFF;
	localparam logic signed [FIELD_W-1:0] FIELD_MIN = 20'sh80000;

	// one classified particle as it travels from the front to the back
	typedef struct packed {
		logic                collided;
		logic signed [20:0]  mx;
		logic signed [20:0]  my;
		logic signed [21:0]  dx;
		logic signed [21:0]  dy;
		logic [31:0]         d2;
		logic signed [19:0]  vx;
		logic signed [19:0]  vy;
		logic signed [19:0]  cx;
		logic signed [19:0]  cy;
		logic [RAD_W-1:0]    r;
		logic [ATT_W-1:0]    att;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [31:0] v);
		logic signed [FIELD_W-1:0] res;
		if (v > 32'(FIELD_MAX))
			res = FIELD_MAX;
		else if (v < 32'(FIELD_MIN))
			res = FIELD_MIN;
		else
			res = v[FIELD_W-1:0];
		return res;
	endfunction

endpackage

// ===== design/pcb_front.sv =====
module pcb_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [pcb_pkg::DT_W-1:0]    time_step,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pcb_pkg::IN_W-1:0]    in_data,
	input  pcb_pkg::q_stat_t            q_stat,
	output logic                        push,
	output pcb_pkg::item_t              push_item
);
	import pcb_pkg::*;

	localparam logic signed [36:0] HALF_P = 37'sd1 <<< (FRAC_BITS - 1);

	logic signed [19:0] px, py, vx, vy, cx, cy;
	logic signed [16:0] dt_s;
	logic signed [36:0] prod_x, prod_y, rnd_x, rnd_y;
	logic signed [20:0] mx_c, my_c;
	logic               fen;

	logic               v_s1;
	logic signed [20:0] mx_s1, my_s1;
	logic signed [19:0] vx_s1, vy_s1, cx_s1, cy_s1;
	logic [RAD_W-1:0]   r_s1;
	logic [ATT_W-1:0]   att_s1;

	logic signed [21:0] dx_c, dy_c;
	logic signed [43:0] sx_c, sy_c;

	logic               v_s2;
	logic signed [20:0] mx_s2, my_s2;
	logic signed [21:0] dx_s2, dy_s2;
	logic [43:0]        sx_s2, sy_s2;
	logic [31:0]        rr_s2;
	logic signed [19:0] vx_s2, vy_s2, cx_s2, cy_s2;
	logic [RAD_W-1:0]   r_s2;
	logic [ATT_W-1:0]   att_s2;
	logic [44:0]        d2_c;

	assign px = $signed(in_data[19:0]);
	assign py = $signed(in_data[39:20]);
	assign vx = $signed(in_data[59:40]);
	assign vy = $signed(in_data[79:60]);
	assign cx = $signed(in_data[99:80]);
	assign cy = $signed(in_data[119:100]);

	// moved position, product rounded half up
	assign dt_s   = $signed({1'b0, time_step});
	assign prod_x = dt_s * vx;
	assign prod_y = dt_s * vy;
	assign rnd_x  = (prod_x + HALF_P) >>> FRAC_BITS;
	assign rnd_y  = (prod_y + HALF_P) >>> FRAC_BITS;
	assign mx_c   = {px[19], px} + rnd_x[20:0];
	assign my_c   = {py[19], py} + rnd_y[20:0];

	assign fen      = !v_s2 || !q_stat.full;
	assign in_ready = fen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (fen) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			mx_s1  <= mx_c;
			my_s1  <= my_c;
			vx_s1  <= vx;
			vy_s1  <= vy;
			cx_s1  <= cx;
			cy_s1  <= cy;
			r_s1   <= in_data[135:120];
			att_s1 <= in_data[153:136];
		end
	end

	// offset from the center and its squares
	assign dx_c = {mx_s1[20], mx_s1} - {{2{cx_s1[19]}}, cx_s1};
	assign dy_c = {my_s1[20], my_s1} - {{2{cy_s1[19]}}, cy_s1};
	assign sx_c = dx_c * dx_c;
	assign sy_c = dy_c * dy_c;

	always_ff @(posedge clk) begin
		if (fen) begin
			mx_s2  <= mx_s1;
			my_s2  <= my_s1;
			dx_s2  <= dx_c;
			dy_s2  <= dy_c;
			sx_s2  <= sx_c;
			sy_s2  <= sy_c;
			rr_s2  <= r_s1 * r_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
			r_s2   <= r_s1;
			att_s2 <= att_s1;
		end
	end

	// classify: inside or on the circle
	assign d2_c = {1'b0, sx_s2} + {1'b0, sy_s2};
	assign push = v_s2 && !q_stat.full;

	always_comb begin
		push_item.collided = d2_c <= {13'b0, rr_s2};
		push_item.mx  = mx_s2;
		push_item.my  = my_s2;
		push_item.dx  = dx_s2;
		push_item.dy  = dy_s2;
		push_item.d2  = d2_c[31:0];
		push_item.vx  = vx_s2;
		push_item.vy  = vy_s2;
		push_item.cx  = cx_s2;
		push_item.cy  = cy_s2;
		push_item.r   = r_s2;
		push_item.att = att_s2;
	end

endmodule

// ===== design/pcb_fifo.sv =====
module pcb_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pcb_pkg::item_t    push_item,
	input  logic              pop,
	output pcb_pkg::item_t    head,
	output pcb_pkg::q_stat_t  q_stat
);
	import pcb_pkg::*;

	item_t             mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_q, rd_q;
	logic [Q_CW-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	assign head         = mem_q[rd_q];
	assign q_stat.full  = cnt_q == Q_CW'(Q_DEPTH);
	assign q_stat.empty = cnt_q == '0;

endmodule

// ===== design/pcb_div.sv =====
module pcb_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [pcb_pkg::DIV_NW-1:0]   num,
	input  logic [pcb_pkg::DIV_DW-1:0]   den,
	output logic [pcb_pkg::DIV_QW-1:0]   quo
);
	import pcb_pkg::*;

	logic [DIV_NW-1:0] rem_s [DIV_QW];
	logic [DIV_DW-1:0] den_s [DIV_QW];
	logic [DIV_QW-1:0] quo_s [DIV_QW];

	// restoring division, one quotient bit per stage, msb first
	for (genvar j = 0; j < DIV_QW; j++) begin : g_st
		localparam int B = DIV_QW - 1 - j;
		logic [DIV_NW-1:0] prem, trial;
		logic [DIV_DW-1:0] pden;
		logic [DIV_QW-1:0] pquo;
		if (j == 0) begin : g_first
			assign prem = num;
			assign pden = den;
			assign pquo = '0;
		end else begin : g_next
			assign prem = rem_s[j-1];
			assign pden = den_s[j-1];
			assign pquo = quo_s[j-1];
		end
		assign trial = {{(DIV_NW-DIV_DW){1'b0}}, pden} << B;
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j] <= pden;
				if (prem >= trial) begin
					rem_s[j] <= prem - trial;
					quo_s[j] <= pquo | (DIV_QW'(1) << B);
				end else begin
					rem_s[j] <= prem;
					quo_s[j] <= pquo;
				end
			end
		end
	end

	assign quo = quo_s[DIV_QW-1];

endmodule

// ===== design/pcb_back.sv =====
module pcb_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcb_pkg::q_stat_t              q_stat,
	input  pcb_pkg::item_t                head,
	output logic                          pop,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [pcb_pkg::OUT_W-1:0]     out_data,
	output logic                          out_collided
);
	import pcb_pkg::*;

	localparam logic [34:0]        HALF_T = 35'd1 << (FRAC_BITS - 1);
	localparam logic signed [42:0] HALF_V = 43'sd1 <<< (FRAC_BITS - 1);

	typedef struct packed {
		logic                collided;
		logic                d2zero;
		logic                vdneg;
		logic                negpx;
		logic                negpy;
		logic                negvx;
		logic                negvy;
		logic [19:0]         s;
		logic signed [20:0]  mx;
		logic signed [20:0]  my;
		logic signed [19:0]  vx;
		logic signed [19:0]  vy;
		logic signed [19:0]  cx;
		logic signed [19:0]  cy;
		logic [ATT_W-1:0]    att;
	} mid_t;

	logic en;

	// square root pipeline
	logic        sqv_s  [SQ_STAGES];
	item_t       sqit_s [SQ_STAGES];
	logic [33:0] rem_s  [SQ_STAGES];
	logic [15:0] root_s [SQ_STAGES];

	logic               v_s17, v_s18, v_s19, v_s20;
	item_t              it_s17, it_s18, it_s19, it_s20;
	logic [15:0]        l_s17, l_s18, l_s19;
	logic [33:0]        t_s17;
	logic signed [36:0] pvx_s17, pvy_s17;
	logic [19:0]        s_s18, s_s19;
	logic signed [37:0] vd_s18;
	logic               vdneg_s19;
	logic signed [37:0] psx_s19, psy_s19;
	logic signed [54:0] pvx_s19, pvy_s19;
	mid_t               mid_s20;
	logic [DIV_NW-1:0]  npx_s20, npy_s20, nvx_s20, nvy_s20;
	logic [DIV_DW-1:0]  dl_s20, dd_s20;

	logic               midv_s [DIV_QW];
	mid_t               mid_s  [DIV_QW];
	logic [DIV_QW-1:0]  qpx, qpy, qvx, qvy;

	logic               v_s43, v_s44;
	mid_t               m_s43;
	logic signed [22:0] nx_s43, ny_s43;
	logic signed [23:0] wx_s43, wy_s43;
	logic               coll_s44;
	logic signed [22:0] nx_s44, ny_s44;
	logic signed [20:0] mx_s44, my_s44;
	logic signed [19:0] vx_s44, vy_s44;
	logic signed [42:0] ax_s44, ay_s44;

	logic               out_valid_q, out_coll_q;
	logic [OUT_W-1:0]   out_data_q;

	logic signed [16:0] dxa, dya, dxc, dyc;
	logic [34:0]        trnd;
	logic [37:0]        mpx, mpy;
	logic [54:0]        mvx, mvy;
	logic [DIV_QW-1:0]  sv_fin_unused;
	logic signed [22:0] tpx, tpy;
	logic signed [23:0] tvx, tvy;
	logic signed [42:0] rvx, rvy;
	logic signed [19:0] opx, opy, ovx, ovy;

	assign en  = !out_valid_q || out_ready;
	assign pop = en && !q_stat.empty;

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
		localparam int B = SQ_STAGES - 1 - k;
		logic        pv;
		item_t       pit;
		logic [33:0] prem, trial;
		logic [15:0] proot;
		if (k == 0) begin : g_first
			assign pv    = !q_stat.empty;
			assign pit   = head;
			assign prem  = {2'b0, head.d2};
			assign proot = '0;
		end else begin : g_next
			assign pv    = sqv_s[k-1];
			assign pit   = sqit_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
		end
		// (root + 2^b)^2 - root^2
		assign trial = ({18'b0, proot} << (B + 1)) + (34'd1 << (2 * B));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sqv_s[k] <= 1'b0;
			else if (en)
				sqv_s[k] <= pv;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sqit_s[k] <= pit;
				if (prem >= trial) begin
					rem_s[k]  <= prem - trial;
					root_s[k] <= proot | (16'd1 << B);
				end else begin
					rem_s[k]  <= prem;
					root_s[k] <= proot;
				end
			end
		end
	end

	assign dxa = $signed(sqit_s[SQ_STAGES-1].dx[16:0]);
	assign dya = $signed(sqit_s[SQ_STAGES-1].dy[16:0]);
	assign trnd = {1'b0, t_s17} + HALF_T;
	assign dxc = $signed(it_s18.dx[16:0]);
	assign dyc = $signed(it_s18.dy[16:0]);
	assign mpx = psx_s19[37] ? 38'(-psx_s19) : 38'(psx_s19);
	assign mpy = psy_s19[37] ? 38'(-psy_s19) : 38'(psy_s19);
	assign mvx = pvx_s19[54] ? 55'(-pvx_s19) : 55'(pvx_s19);
	assign mvy = pvy_s19[54] ? 55'(-pvy_s19) : 55'(pvy_s19);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s17 <= 1'b0;
			v_s18 <= 1'b0;
			v_s19 <= 1'b0;
			v_s20 <= 1'b0;
		end else if (en) begin
			v_s17 <= sqv_s[SQ_STAGES-1];
			v_s18 <= v_s17;
			v_s19 <= v_s18;
			v_s20 <= v_s19;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s17  <= sqit_s[SQ_STAGES-1];
			l_s17   <= root_s[SQ_STAGES-1];
			t_s17   <= sqit_s[SQ_STAGES-1].att *
				(sqit_s[SQ_STAGES-1].r - root_s[SQ_STAGES-1]);
			pvx_s17 <= sqit_s[SQ_STAGES-1].vx * dxa;
			pvy_s17 <= sqit_s[SQ_STAGES-1].vy * dya;

			it_s18  <= it_s17;
			l_s18   <= l_s17;
			s_s18   <= {4'b0, it_s17.r} + trnd[35-1-FRAC_BITS+FRAC_BITS-16+16-1:FRAC_BITS] ;
			vd_s18  <= {pvx_s17[36], pvx_s17} + {pvy_s17[36], pvy_s17};

			it_s19    <= it_s18;
			l_s19     <= l_s18;
			s_s19     <= s_s18;
			vdneg_s19 <= vd_s18[37];
			psx_s19   <= $signed({1'b0, s_s18}) * dxc;
			psy_s19   <= $signed({1'b0, s_s18}) * dyc;
			pvx_s19   <= vd_s18 * dxc;
			pvy_s19   <= vd_s18 * dyc;

			// magnitudes plus half the divisor, rounding ties away from zero
			it_s20  <= it_s19;
			npx_s20 <= {18'b0, mpx} + {41'b0, l_s19[15:1]};
			npy_s20 <= {18'b0, mpy} + {41'b0, l_s19[15:1]};
			nvx_s20 <= {mvx, 1'b0} + {25'b0, it_s19.d2[31:1]};
			nvy_s20 <= {mvy, 1'b0} + {25'b0, it_s19.d2[31:1]};
			dl_s20  <= {16'b0, l_s19};
			dd_s20  <= it_s19.d2;
			mid_s20.collided <= it_s19.collided;
			mid_s20.d2zero   <= it_s19.d2 == '0;
			mid_s20.vdneg    <= vdneg_s19;
			mid_s20.negpx    <= psx_s19[37];
			mid_s20.negpy    <= psy_s19[37];
			mid_s20.negvx    <= pvx_s19[54];
			mid_s20.negvy    <= pvy_s19[54];
			mid_s20.s        <= s_s19;
			mid_s20.mx       <= it_s19.mx;
			mid_s20.my       <= it_s19.my;
			mid_s20.vx       <= it_s19.vx;
			mid_s20.vy       <= it_s19.vy;
			mid_s20.cx       <= it_s19.cx;
			mid_s20.cy       <= it_s19.cy;
			mid_s20.att      <= it_s19.att;
		end
	end

	pcb_div u_div_px (.clk(clk), .en(en), .num(npx_s20), .den(dl_s20), .quo(qpx));
	pcb_div u_div_py (.clk(clk), .en(en), .num(npy_s20), .den(dl_s20), .quo(qpy));
	pcb_div u_div_vx (.clk(clk), .en(en), .num(nvx_s20), .den(dd_s20), .quo(qvx));
	pcb_div u_div_vy (.clk(clk), .en(en), .num(nvy_s20), .den(dd_s20), .quo(qvy));

	// side data rides alongside the dividers
	for (genvar j = 0; j < DIV_QW; j++) begin : g_side
		logic pv;
		mid_t pm;
		if (j == 0) begin : g_first
			assign pv = v_s20;
			assign pm = mid_s20;
		end else begin : g_next
			assign pv = midv_s[j-1];
			assign pm = mid_s[j-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				midv_s[j] <= 1'b0;
			else if (en)
				midv_s[j] <= pv;
		end
		always_ff @(posedge clk) begin
			if (en)
				mid_s[j] <= pm;
		end
	end

	assign sv_fin_unused = '0;
	assign tpx = mid_s[DIV_QW-1].negpx ? -$signed({1'b0, qpx}) : $signed({1'b0, qpx});
	assign tpy = mid_s[DIV_QW-1].negpy ? -$signed({1'b0, qpy}) : $signed({1'b0, qpy});
	assign tvx = mid_s[DIV_QW-1].negvx ? -$signed({2'b0, qvx}) : $signed({2'b0, qvx});
	assign tvy = mid_s[DIV_QW-1].negvy ? -$signed({2'b0, qvy}) : $signed({2'b0, qvy});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s43 <= 1'b0;
			v_s44 <= 1'b0;
		end else if (en) begin
			v_s43 <= midv_s[DIV_QW-1];
			v_s44 <= v_s43;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s43 <= mid_s[DIV_QW-1];
			// moved position on the center: normal taken as +x
			if (mid_s[DIV_QW-1].d2zero) begin
				nx_s43 <= {{3{mid_s[DIV_QW-1].cx[19]}}, mid_s[DIV_QW-1].cx}
					+ {3'b0, mid_s[DIV_QW-1].s};
				ny_s43 <= {{3{mid_s[DIV_QW-1].cy[19]}}, mid_s[DIV_QW-1].cy};
			end else begin
				nx_s43 <= {{3{mid_s[DIV_QW-1].cx[19]}}, mid_s[DIV_QW-1].cx} + tpx;
				ny_s43 <= {{3{mid_s[DIV_QW-1].cy[19]}}, mid_s[DIV_QW-1].cy} + tpy;
			end
			// reflect only when heading inward
			if (mid_s[DIV_QW-1].vdneg) begin
				wx_s43 <= {{4{mid_s[DIV_QW-1].vx[19]}}, mid_s[DIV_QW-1].vx} - tvx;
				wy_s43 <= {{4{mid_s[DIV_QW-1].vy[19]}}, mid_s[DIV_QW-1].vy} - tvy;
			end else begin
				wx_s43 <= {{4{mid_s[DIV_QW-1].vx[19]}}, mid_s[DIV_QW-1].vx};
				wy_s43 <= {{4{mid_s[DIV_QW-1].vy[19]}}, mid_s[DIV_QW-1].vy};
			end

			coll_s44 <= m_s43.collided;
			nx_s44   <= nx_s43;
			ny_s44   <= ny_s43;
			mx_s44   <= m_s43.mx;
			my_s44   <= m_s43.my;
			vx_s44   <= m_s43.vx;
			vy_s44   <= m_s43.vy;
			ax_s44   <= $signed({1'b0, m_s43.att}) * wx_s43;
			ay_s44   <= $signed({1'b0, m_s43.att}) * wy_s43;
		end
	end

	assign rvx = (ax_s44 + HALF_V) >>> FRAC_BITS;
	assign rvy = (ay_s44 + HALF_V) >>> FRAC_BITS;

	always_comb begin
		if (coll_s44) begin
			opx = sat_field({{9{nx_s44[22]}}, nx_s44});
			opy = sat_field({{9{ny_s44[22]}}, ny_s44});
			ovx = sat_field($signed(rvx[31:0]));
			ovy = sat_field($signed(rvy[31:0]));
		end else begin
			opx = sat_field({{11{mx_s44[20]}}, mx_s44});
			opy = sat_field({{11{my_s44[20]}}, my_s44});
			ovx = vx_s44;
			ovy = vy_s44;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= v_s44;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {ovy, ovx, opy, opx} | {{(OUT_W-DIV_QW){1'b0}}, sv_fin_unused};
			out_coll_q <= coll_s44;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;
	assign out_collided = out_coll_q;

endmodule

// ===== design/particle_circle_bounce_step.sv =====
// an accepted request passes 2 front stages, the queue, 16 square root stages,
//   4 product stages, 22 divider stages, 2 final stages and the output register
// throughput: one request per cycle, set by the fully pipelined root and dividers,
//   while m_axis_tready does not stall the output
// reset: arst_n clears all valid bits, the queue pointers and loads time_step = 328
`include "particle_circle_bounce_step_defines.svh"

module particle_circle_bounce_step (
	input  logic                          clk,
	input  logic                          arst_n,
	// time step register, q0.16 seconds
	input  logic                          cfg_we,
	input  logic [pcb_pkg::DT_W-1:0]      cfg_wdata,
	// request side
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// pos_x, pos_y, vel_x, vel_y, center_x, center_y, radius, attenuation, 6 pad bits
	input  logic [pcb_pkg::IN_W-1:0]      s_axis_tdata,
	// result side
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// new_pos_x, new_pos_y, new_vel_x, new_vel_y
	output logic [pcb_pkg::OUT_W-1:0]     m_axis_tdata,
	// collided
	output logic                          m_axis_tuser
);
	import pcb_pkg::*;

	logic [DT_W-1:0] time_step_q;
	logic            q_push, q_pop;
	item_t           q_in, q_head;
	q_stat_t         q_stat;

	// the user changes the time step only while the block is idle; it is not enforced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			time_step_q <= DT_RESET;
		else if (cfg_we)
			time_step_q <= cfg_wdata;
	end

	// front: moved position, offset from the center, inside test
	pcb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.time_step (time_step_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.q_stat    (q_stat),
		.push      (q_push),
		.push_item (q_in)
	);

	// short queue so front and back stall on their own
	pcb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.q_stat    (q_stat)
	);

	// back: distance root, push-out, reflection, attenuation, saturation
	pcb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.head         (q_head),
		.pop          (q_pop),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_data     (m_axis_tdata),
		.out_collided (m_axis_tuser)
	);

	// the front only backs up when the queue is full
	`PCB_ASSERT_SAME(a_ready_low_full, !s_axis_tready, q_stat.full, "ready low with room")
	// a stalled result freezes the back, so nothing leaves the queue
	`PCB_ASSERT_SAME(a_stall_no_pop, m_axis_tvalid && !m_axis_tready, !q_pop, "pop on stall")
	// a push that is not drained leaves the queue occupied
	`PCB_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_stat.empty, "queue lost a push")

endmodule
